// File: sv/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; used by the channel interfaces and the top level.
package wbps_pkg;

  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int PATTERN_WORDS = 4;
  localparam int WORD_W        = 64;
  localparam int MASK_W        = 32;
  localparam int LENGTH_W      = 6;
  localparam int ADDR_W        = 64;
  localparam int BYTE_W        = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_WORD_0,
    REG_PATTERN_WORD_1,
    REG_PATTERN_WORD_2,
    REG_PATTERN_WORD_3,
    REG_WILDCARD_MASK,
    REG_PATTERN_LENGTH,
    REG_MODULE_BASE
  } cfg_reg_t;

endpackage

// File: sv/wbps_if.sv
// Valid/ready channel interfaces for the scanner: image bytes in, results out.
// Depends on wbps_pkg for field widths.
interface wbps_in_if;
  logic                       valid;
  logic                       ready;
  logic [wbps_pkg::BYTE_W-1:0] data_byte;
  logic                       first_byte;
  logic                       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface wbps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [wbps_pkg::ADDR_W-1:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

// File: sv/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg and the channel interfaces in wbps_if.sv.
//
// Takes one image byte per cycle and reports the first match of a pattern of up
// to MAX_PATTERN_BYTES bytes with per-byte wildcards, as module_base plus the
// start offset, or found=0 on the last byte when nothing matched. A byte is
// accepted every cycle as long as the result side keeps up; the shift-and
// prefix vector and byte counter update in the cycle a byte is accepted. A
// result passes through two registers on its way to the output: the first
// holds the hit and offset, the second holds the final address
// (base add). The output stage holds while its result is not taken; the first
// stage holds only while it carries a result behind it, and input ready drops
// only when both are full. Configuration must be written while no transaction
// is in flight.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  wbps_in_if.sink                           in_ch,
  wbps_out_if.source                        out_ch
);

  localparam int HIT_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int LEN_W     = wbps_pkg::LENGTH_W;

  // configuration
  logic [wbps_pkg::WORD_W-1:0]   pattern_word_r [wbps_pkg::PATTERN_WORDS];
  logic [wbps_pkg::MASK_W-1:0]   wildcard_mask_r;
  logic [LEN_W-1:0]              pattern_length_r;
  logic [wbps_pkg::ADDR_W-1:0]   module_base_r;

  // scan state
  logic [MAX_PATTERN_BYTES-1:0]  prefix_hits_r;
  logic [OFFSET_BITS-1:0]        byte_count_r;
  logic                          match_reported_r;

  // pipeline
  logic                          s1_valid_r;
  logic                          s1_found_r;
  logic [OFFSET_BITS-1:0]        s1_offset_r;
  logic                          out_valid_r;
  logic                          out_found_r;
  logic [wbps_pkg::ADDR_W-1:0]   out_addr_r;

  logic [wbps_pkg::PATTERN_WORDS*wbps_pkg::WORD_W-1:0] pat_flat;
  logic [MAX_PATTERN_BYTES-1:0]  eq;
  logic [MAX_PATTERN_BYTES-1:0]  prefix_base;
  logic [MAX_PATTERN_BYTES-1:0]  prefix_nxt;
  logic [OFFSET_BITS-1:0]        count_base;
  logic [OFFSET_BITS-1:0]        count_nxt;
  logic                          reported_base;
  logic                          reported_nxt;
  logic [LEN_W-1:0]              len_eff;
  logic [HIT_IDX_W-1:0]          hit_idx;
  logic [OFFSET_BITS-1:0]        len_ext;
  logic [OFFSET_BITS-1:0]        offset;
  logic                          hit;
  logic                          emit;
  logic                          accept;
  logic                          s2_ready;
  logic                          s1_ready;

  assign s2_ready     = !out_valid_r || out_ch.ready;
  assign s1_ready     = !s1_valid_r || s2_ready;
  assign in_ch.ready  = s1_ready;
  assign accept       = in_ch.valid && s1_ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.match_address = out_addr_r;

  assign pat_flat = {pattern_word_r[3], pattern_word_r[2], pattern_word_r[1], pattern_word_r[0]};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      eq[i] = wildcard_mask_r[i] ||
              (pat_flat[wbps_pkg::BYTE_W*i +: wbps_pkg::BYTE_W] == in_ch.data_byte);
    end
  end

  // first_byte restarts the image before this byte is taken in
  always_comb begin
    prefix_base   = in_ch.first_byte ? '0 : prefix_hits_r;
    count_base    = in_ch.first_byte ? '0 : byte_count_r;
    reported_base = in_ch.first_byte ? 1'b0 : match_reported_r;

    prefix_nxt = {prefix_base[MAX_PATTERN_BYTES-2:0], 1'b1} & eq;
    count_nxt  = (count_base == {OFFSET_BITS{1'b1}}) ? count_base :
                 count_base + OFFSET_BITS'(1);

    len_eff = (pattern_length_r > LEN_W'(MAX_PATTERN_BYTES)) ?
              LEN_W'(MAX_PATTERN_BYTES) : pattern_length_r;
    hit_idx = HIT_IDX_W'(len_eff - LEN_W'(1));
    hit     = (len_eff != '0) && (module_base_r != '0) && prefix_nxt[hit_idx];
    emit    = !reported_base && (hit || in_ch.last_byte);

    len_ext = OFFSET_BITS'(len_eff);
    offset  = (count_nxt >= len_ext) ? count_nxt - len_ext : '0;

    reported_nxt = reported_base || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < wbps_pkg::PATTERN_WORDS; w++) begin
        pattern_word_r[w] <= '0;
      end
      wildcard_mask_r  <= '0;
      pattern_length_r <= '0;
      module_base_r    <= '0;
    end else if (cfg_we) begin
      case (wbps_pkg::cfg_reg_t'(cfg_index))
        wbps_pkg::REG_PATTERN_WORD_0: pattern_word_r[0] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD_1: pattern_word_r[1] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD_2: pattern_word_r[2] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD_3: pattern_word_r[3] <= cfg_data;
        wbps_pkg::REG_WILDCARD_MASK:  wildcard_mask_r  <= cfg_data[wbps_pkg::MASK_W-1:0];
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
        wbps_pkg::REG_MODULE_BASE:    module_base_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_hits_r    <= '0;
      byte_count_r     <= '0;
      match_reported_r <= 1'b0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        prefix_hits_r    <= prefix_nxt;
        byte_count_r     <= count_nxt;
        match_reported_r <= reported_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= accept && emit;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_found_r  <= hit;
      s1_offset_r <= offset;
    end
    if (s2_ready) begin
      out_found_r <= s1_found_r;
      out_addr_r  <= s1_found_r ?
                     module_base_r + wbps_pkg::ADDR_W'(s1_offset_r) : '0;
    end
  end

endmodule

// File: sv/wbps_checker.sv
// Port-level checks for the wildcard byte pattern scanner.
// Depends on wbps_pkg; bound to wildcard_byte_pattern_scanner below.
module wbps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [wbps_pkg::ADDR_W-1:0]  out_match_address
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_match_address))
    else $error("result changed while stalled");

  // not-found results carry a zero address
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("not-found result with nonzero address");

  // a new result must trace back to a byte transaction taken through the s1 and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a byte transaction two cycles earlier");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_found         (out_ch.found),
  .out_match_address (out_ch.match_address)
);
